// ===== hdl/fdg_pkg.sv =====
package fdg_pkg;

    localparam int UP_DEPTH_DEF  = 256;
    localparam int TIME_BITS_DEF = 48;
    localparam int Z_BITS        = 16;
    localparam int WIN_BITS      = 32;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;
    localparam int OUT_BITS      = 8;

    localparam logic [CFG_IDX_BITS-1:0] REG_DOWN_THR = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_UP_THR   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW   = 2'd2;

    localparam logic signed [Z_BITS-1:0] DOWN_THR_RST = -16'sd9215;
    localparam logic signed [Z_BITS-1:0] UP_THR_RST   = 16'sd9215;
    localparam logic [WIN_BITS-1:0]      WINDOW_RST   = 32'd2000000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CHECK,
        ST_AGE,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic load;
        logic pop;
        logic age;
        logic decide;
    } dp_cmd_t;

    typedef struct packed {
        logic expire_hit;
        logic out_stall;
    } dp_status_t;

endpackage

// ===== hdl/fdg_ram.sv =====
module fdg_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/fdg_ctrl.sv =====
module fdg_ctrl
    import fdg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = status.expire_hit ? ST_FETCH : ST_AGE;
            end
            ST_AGE:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (!status.out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_FETCH:
            begin
                cmd = '0;
            end
            ST_CHECK:
            begin
                cmd.pop = status.expire_hit;
            end
            ST_AGE:
            begin
                cmd.age = 1'b1;
            end
            ST_DECIDE:
            begin
                cmd.decide = !status.out_stall;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== hdl/fdg_datapath.sv =====
module fdg_datapath
    import fdg_pkg::*;
#(
    parameter int UP_DEPTH  = UP_DEPTH_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic [TIME_BITS-1:0]     in_time,
    input  logic signed [Z_BITS-1:0] in_z,
    input  dp_cmd_t                  cmd,
    output dp_status_t               status,
    input  logic                     m_tready,
    output logic                     m_tvalid,
    output logic [OUT_BITS-1:0]      m_tdata
);

    localparam int AW = $clog2(UP_DEPTH);
    localparam int CW = $clog2(UP_DEPTH + 1);

    logic signed [Z_BITS-1:0] down_thr_reg;
    logic signed [Z_BITS-1:0] up_thr_reg;
    logic [WIN_BITS-1:0]      window_reg;

    logic [TIME_BITS-1:0]     t_reg;
    logic signed [Z_BITS-1:0] z_reg;
    logic [TIME_BITS-1:0]     last_event_reg;
    logic [TIME_BITS-1:0]     latest_down_reg;
    logic [TIME_BITS-1:0]     latest_down_next;
    logic [AW-1:0]            head_reg;
    logic [CW-1:0]            count_reg;
    logic                     overflow_reg;

    logic [TIME_BITS-1:0]     down_age_reg;
    logic [TIME_BITS-1:0]     up_age_reg;
    logic [TIME_BITS-1:0]     hold_age_reg;
    logic                     has_up_reg;

    logic                     out_valid_reg;
    logic [OUT_BITS-1:0]      out_data_reg;

    logic [TIME_BITS-1:0]     rd_data;
    logic [TIME_BITS-1:0]     window_ext;
    logic [TIME_BITS-1:0]     head_age;
    logic                     fifo_nonempty;
    logic                     fifo_full;
    logic                     is_up;
    logic                     push_ok;
    logic [AW:0]              slot_sum;
    logic [AW-1:0]            slot;
    logic [AW-1:0]            head_inc;
    logic                     event_hit;

    assign window_ext    = TIME_BITS'(window_reg);
    assign head_age      = t_reg - rd_data;
    assign fifo_nonempty = (count_reg != '0);
    assign fifo_full     = (count_reg == CW'(UP_DEPTH));
    assign is_up         = (z_reg > up_thr_reg);
    assign push_ok       = cmd.age && is_up && !fifo_full;

    assign slot_sum = {1'b0, head_reg} + (AW + 1)'(count_reg);
    assign slot     = (slot_sum >= (AW + 1)'(UP_DEPTH))
                    ? AW'(slot_sum - (AW + 1)'(UP_DEPTH)) : slot_sum[AW-1:0];
    assign head_inc = (head_reg == AW'(UP_DEPTH - 1)) ? '0 : head_reg + AW'(1);

    assign latest_down_next = (z_reg < down_thr_reg) ? t_reg : latest_down_reg;

    assign event_hit = has_up_reg && (down_age_reg < window_ext)
                    && (down_age_reg <= up_age_reg) && (hold_age_reg >= window_ext);

    assign status.expire_hit = fifo_nonempty && (head_age > window_ext);
    assign status.out_stall  = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    fdg_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (UP_DEPTH)
    ) u_up_ram (
        .clk   (clk),
        .we    (push_ok),
        .waddr (slot),
        .wdata (t_reg),
        .raddr (head_reg),
        .rdata (rd_data)
    );

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            down_thr_reg <= DOWN_THR_RST;
            up_thr_reg   <= UP_THR_RST;
            window_reg   <= WINDOW_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DOWN_THR: down_thr_reg <= cfg_data[Z_BITS-1:0];
                REG_UP_THR:   up_thr_reg   <= cfg_data[Z_BITS-1:0];
                REG_WINDOW:   window_reg   <= cfg_data[WIN_BITS-1:0];
                default:      window_reg   <= window_reg;
            endcase
        end
    end

    // sample word and computed ages
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            z_reg <= in_z;
        end
        if (cmd.age)
        begin
            down_age_reg <= t_reg - latest_down_next;
            up_age_reg   <= fifo_nonempty ? head_age : '0;
            hold_age_reg <= t_reg - last_event_reg;
            has_up_reg   <= fifo_nonempty || push_ok;
        end
        if (cmd.decide)
        begin
            out_data_reg <= OUT_BITS'({overflow_reg, event_hit});
        end
    end

    // detector state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg           <= '0;
            last_event_reg  <= '0;
            latest_down_reg <= '0;
            head_reg        <= '0;
            count_reg       <= '0;
            overflow_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                t_reg <= in_time;
            end
            if (cmd.pop)
            begin
                head_reg  <= head_inc;
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.age)
            begin
                latest_down_reg <= latest_down_next;
                if (push_ok)
                begin
                    count_reg <= count_reg + CW'(1);
                end
                if (is_up && fifo_full)
                begin
                    overflow_reg <= 1'b1;
                end
            end
            if (cmd.decide)
            begin
                out_valid_reg <= 1'b1;
                if (event_hit)
                begin
                    last_event_reg <= t_reg;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== hdl/face_down_gesture_detector_unit.sv =====
// channel  dir  handshake              payload
// s_       in   s_tvalid / s_tready    s_tdata: sample_time, z_accel
// m_       out  m_tvalid / m_tready    m_tdata: face_down, up_overflow
// cfg_     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// between accepts a sample steps through fetch, check, age and decide states;
// the result word is registered in decide, and each stale face-up entry expired
// adds a fetch and check, as the expiry waits on the registered face-up ram read
// one sample is in flight at a time; the result register frees the input side
// a stalled m_ side holds the last step of the sample until the word is taken
// rst_n clears fsm and detector state at once; face-up ram needs no clearing pass
module face_down_gesture_detector_unit
    import fdg_pkg::*;
#(
    parameter int UP_DEPTH  = UP_DEPTH_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // sample_time, z_accel
    input  logic [((TIME_BITS + Z_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // face_down, up_overflow
    output logic [OUT_BITS-1:0]      m_tdata,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    fdg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fdg_datapath #(
        .UP_DEPTH  (UP_DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_time   (s_tdata[TIME_BITS-1:0]),
        .in_z      (s_tdata[TIME_BITS+Z_BITS-1:TIME_BITS]),
        .cmd       (cmd),
        .status    (status),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule
